// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and helper functions for the wheel odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS  = 24;
    localparam int POS_FRAC_BITS = 16;

    localparam logic [29:0] BAM_PER_RAD  = 30'd683565276;
    localparam logic [32:0] CORDIC_START = 33'sd652032874;
    localparam logic [19:0] US_PER_S     = 20'd1000000;

    // Width of the velocity dividend (angular case is the widest)
    localparam int DVD_W = 73;

    localparam logic [6:0] MUL_N_DPC = 7'd24;
    localparam logic [6:0] MUL_N_BAM = 7'd30;
    localparam logic [6:0] MUL_N_DD  = 7'd33;
    localparam logic [6:0] MUL_N_TRG = 7'd32;
    localparam logic [6:0] MUL_N_US  = 7'd20;
    localparam logic [6:0] MUL_N_P   = 7'd48;

    // Position step: product bit where the kept field starts (rounding bit)
    localparam int ADV_LO = 54 - POS_FRAC_BITS;

    typedef enum logic [0:0] {
        REG_DIST_PER_COUNT = 1'b0,
        REG_INV_WHEEL_BASE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic               counts_valid;
        logic [19:0]        elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic signed [31:0] lin_velocity;
        logic signed [31:0] ang_velocity;
    } t_out_word;

    typedef struct packed {
        logic       start;
        logic [6:0] n;
    } t_mul_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL_DS,
        ST_MUL_P,
        ST_MUL_KQ,
        ST_MUL_U,
        ST_HEAD,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_LIN,
        ST_DIV_LIN,
        ST_MUL_ANG1,
        ST_MUL_ANG2,
        ST_DIV_ANG,
        ST_OUT
    } t_state;

    // Arctangent of 2^-i in binary-angle units
    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Saturate a velocity quotient and apply its sign; zero time gives zero
    function automatic logic [31:0] sat_rate(input logic [DVD_W-1:0] q, input logic neg,
                                             input logic [19:0] us);
        logic [31:0] cap;
        logic [31:0] m;
        cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (|q[DVD_W-1:32]) begin
            m = cap;
        end else if (q[31:0] > cap) begin
            m = cap;
        end else begin
            m = q[31:0];
        end
        if (us == 20'd0) begin
            return 32'd0;
        end
        return neg ? (32'd0 - m) : m;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry.sv =====
// Top level of the differential-drive wheel odometry integrator.
//
// Input channel: one word per encoder tick (cumulative counts, valid flag,
// elapsed microseconds), taken on i_in_valid & o_in_ready. Output channel:
// one word per input word (pose and velocities), held on o_out_valid until
// i_out_ready. Config: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 distance per count, 1 inverse wheel base) at once; write only when idle.
//
// Steps: a word with valid counts runs the delta step, four multiplies, the
// heading step, the CORDIC (load plus 24 rotations), three multiplies, a divide,
// two multiplies, a divide and the output step: nine serial multiplies at one
// multiplier bit per cycle (24, 24, 30, 33, 32, 32, 20, 20 and 48 steps) and
// two 73-step divides. A word with invalid counts goes straight to the output
// step. One word is worked on at a time; the next word can only be taken once
// the result is loaded and the sequencer is back to idle.
// A finished word waits in the output register; a stalled receiver holds the
// sequencer at its last step until the register frees up.
// Reset clears the pose, the last counts and the handshakes and restores the
// register defaults.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;
    logic   r_go;

    logic [23:0] r_dpc;
    logic [23:0] r_ibw;
    t_in_word    r_in;
    logic [31:0] r_prev_l;
    logic [31:0] r_prev_r;
    logic [31:0] r_acc_x;
    logic [31:0] r_acc_y;
    logic [31:0] r_acc_h;

    logic [32:0] r_sum;
    logic [32:0] r_dd;
    logic [56:0] r_ds2;
    logic [47:0] r_p;
    logic [57:0] r_kq;
    logic [56:0] r_u;
    logic [31:0] r_dh;
    logic [31:0] r_half;
    logic [32:0] r_cx;
    logic [32:0] r_cy;
    logic [32:0] r_cz;
    logic        r_flip;
    logic [4:0]  r_ci;
    logic [52:0] r_t;
    logic [DVD_W-1:0] r_dvd;
    logic [31:0] r_lin;
    logic [31:0] r_ang;

    logic      r_out_valid;
    t_out_word r_out;

    // unit hookups
    t_mul_req         w_mreq;
    logic [63:0]      w_ma;
    logic [63:0]      w_mb;
    logic             w_mdone;
    logic [127:0]     w_prod;
    logic             w_dstart;
    logic             w_ddone;
    logic [DVD_W-1:0] w_quo;

    // combinational helpers
    logic        w_accept;
    logic        w_out_free;
    logic [31:0] w_dl;
    logic [31:0] w_dr;
    logic [32:0] w_sum_abs;
    logic [32:0] w_dd_abs;
    logic [32:0] w_cs;
    logic [32:0] w_sn;
    logic [32:0] w_cs_abs;
    logic [32:0] w_sn_abs;
    logic [32:0] w_adv;
    logic [31:0] w_adv_m;
    logic        w_neg_x;
    logic        w_neg_y;
    logic [56:0] w_u1;
    logic [56:0] w_u2;
    logic [31:0] w_ang;
    logic        w_fold;
    logic [31:0] w_ang_f;
    logic [32:0] w_shx;
    logic [32:0] w_shy;
    logic [32:0] w_atan;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_dl      = r_in.left_count - r_prev_l;
    assign w_dr      = r_in.right_count - r_prev_r;
    assign w_sum_abs = r_sum[32] ? (33'd0 - r_sum) : r_sum;
    assign w_dd_abs  = r_dd[32] ? (33'd0 - r_dd) : r_dd;
    assign w_cs      = r_flip ? (33'd0 - r_cx) : r_cx;
    assign w_sn      = r_flip ? (33'd0 - r_cy) : r_cy;
    assign w_cs_abs  = w_cs[32] ? (33'd0 - w_cs) : w_cs;
    assign w_sn_abs  = w_sn[32] ? (33'd0 - w_sn) : w_sn;
    assign w_neg_x   = r_sum[32] != w_cs[32];
    assign w_neg_y   = r_sum[32] != w_sn[32];

    // round the position step half up
    assign w_adv   = w_prod[ADV_LO+32:ADV_LO] + 33'd1;
    assign w_adv_m = w_adv[32:1];

    assign w_u1 = r_u + 57'd8388608;
    assign w_u2 = r_u + 57'd16777216;

    // fold the midpoint heading into the right half plane
    assign w_ang   = r_acc_h + r_half;
    assign w_fold  = w_ang[31] ^ w_ang[30];
    assign w_ang_f = {w_ang[31] ^ w_fold, w_ang[30:0]};

    assign w_shx  = $signed(r_cx) >>> r_ci;
    assign w_shy  = $signed(r_cy) >>> r_ci;
    assign w_atan = {1'b0, atan_bam(r_ci)};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_accept) begin
                n_state = i_in_word.counts_valid ? ST_DELTA : ST_OUT;
            end
            ST_DELTA:    n_state = ST_MUL_DS;
            ST_MUL_DS:   if (w_mdone) n_state = ST_MUL_P;
            ST_MUL_P:    if (w_mdone) n_state = ST_MUL_KQ;
            ST_MUL_KQ:   if (w_mdone) n_state = ST_MUL_U;
            ST_MUL_U:    if (w_mdone) n_state = ST_HEAD;
            ST_HEAD:     n_state = ST_CORDIC;
            ST_CORDIC:   if (!r_go && r_ci == 5'(CORDIC_STEPS - 1)) n_state = ST_MUL_X;
            ST_MUL_X:    if (w_mdone) n_state = ST_MUL_Y;
            ST_MUL_Y:    if (w_mdone) n_state = ST_MUL_LIN;
            ST_MUL_LIN:  if (w_mdone) n_state = ST_DIV_LIN;
            ST_DIV_LIN:  if (w_ddone) n_state = ST_MUL_ANG1;
            ST_MUL_ANG1: if (w_mdone) n_state = ST_MUL_ANG2;
            ST_MUL_ANG2: if (w_mdone) n_state = ST_DIV_ANG;
            ST_DIV_ANG:  if (w_ddone) n_state = ST_OUT;
            ST_OUT:      if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // unit operands and start strobes
    always_comb begin
        w_mreq.start = 1'b0;
        w_mreq.n     = MUL_N_DPC;
        w_ma         = 64'd0;
        w_mb         = 64'd0;
        w_dstart     = 1'b0;
        unique case (r_state)
            ST_MUL_DS: begin
                w_mreq = '{start: r_go, n: MUL_N_DPC};
                w_ma   = 64'(w_sum_abs);
                w_mb   = 64'(r_dpc);
            end
            ST_MUL_P: begin
                w_mreq = '{start: r_go, n: MUL_N_DPC};
                w_ma   = 64'(r_ibw);
                w_mb   = 64'(r_dpc);
            end
            ST_MUL_KQ: begin
                w_mreq = '{start: r_go, n: MUL_N_BAM};
                w_ma   = 64'(r_p);
                w_mb   = 64'(BAM_PER_RAD);
            end
            ST_MUL_U: begin
                w_mreq = '{start: r_go, n: MUL_N_DD};
                w_ma   = 64'(r_kq);
                w_mb   = 64'(w_dd_abs);
            end
            ST_MUL_X: begin
                w_mreq = '{start: r_go, n: MUL_N_TRG};
                w_ma   = 64'(r_ds2);
                w_mb   = 64'(w_cs_abs);
            end
            ST_MUL_Y: begin
                w_mreq = '{start: r_go, n: MUL_N_TRG};
                w_ma   = 64'(r_ds2);
                w_mb   = 64'(w_sn_abs);
            end
            ST_MUL_LIN: begin
                w_mreq = '{start: r_go, n: MUL_N_US};
                w_ma   = 64'(r_ds2);
                w_mb   = 64'(US_PER_S);
            end
            ST_MUL_ANG1: begin
                w_mreq = '{start: r_go, n: MUL_N_US};
                w_ma   = 64'(w_dd_abs);
                w_mb   = 64'(US_PER_S);
            end
            ST_MUL_ANG2: begin
                w_mreq = '{start: r_go, n: MUL_N_P};
                w_ma   = 64'(r_t);
                w_mb   = 64'(r_p);
            end
            ST_DIV_LIN, ST_DIV_ANG: begin
                w_dstart = r_go;
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_dvd   (r_dvd),
        .i_dvs   (r_in.elapsed_us),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // state, config, pose and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_dpc       <= 24'd41431;
            r_ibw       <= 24'd2688656;
            r_prev_l    <= 32'd0;
            r_prev_r    <= 32'd0;
            r_acc_x     <= 32'd0;
            r_acc_y     <= 32'd0;
            r_acc_h     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_DIST_PER_COUNT: r_dpc <= i_cfg_data;
                    REG_INV_WHEEL_BASE: r_ibw <= i_cfg_data;
                    default:            r_dpc <= r_dpc;
                endcase
            end
            if (r_state == ST_DELTA) begin
                r_prev_l <= r_in.left_count;
                r_prev_r <= r_in.right_count;
            end
            if (r_state == ST_MUL_X && w_mdone) begin
                r_acc_x <= r_acc_x + (w_neg_x ? (32'd0 - w_adv_m) : w_adv_m);
            end
            if (r_state == ST_MUL_Y && w_mdone) begin
                r_acc_y <= r_acc_y + (w_neg_y ? (32'd0 - w_adv_m) : w_adv_m);
            end
            if (r_state == ST_DIV_ANG && w_ddone) begin
                r_acc_h <= r_acc_h + r_dh;
            end
            // drop the word once taken, load a new one when free
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in  <= i_in_word;
            r_lin <= 32'd0;
            r_ang <= 32'd0;
        end
        unique case (r_state)
            ST_DELTA: begin
                r_sum <= {w_dl[31], w_dl} + {w_dr[31], w_dr};
                r_dd  <= {w_dr[31], w_dr} - {w_dl[31], w_dl};
            end
            ST_MUL_DS:   if (w_mdone) r_ds2 <= w_prod[56:0];
            ST_MUL_P:    if (w_mdone) r_p <= w_prod[47:0];
            ST_MUL_KQ:   if (w_mdone) r_kq <= w_prod[77:20];
            ST_MUL_U:    if (w_mdone) begin
                r_u <= r_dd[32] ? (57'd0 - w_prod[56:0]) : w_prod[56:0];
            end
            ST_HEAD: begin
                r_dh   <= w_u1[55:24];
                r_half <= w_u2[56:25];
            end
            ST_CORDIC: begin
                if (r_go) begin
                    r_cx   <= CORDIC_START;
                    r_cy   <= 33'd0;
                    r_cz   <= {w_ang_f[31], w_ang_f};
                    r_flip <= w_fold;
                    r_ci   <= 5'd0;
                end else begin
                    // rotate toward zero residual angle
                    if (!r_cz[32]) begin
                        r_cx <= r_cx - w_shy;
                        r_cy <= r_cy + w_shx;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_shy;
                        r_cy <= r_cy - w_shx;
                        r_cz <= r_cz + w_atan;
                    end
                    r_ci <= r_ci + 5'd1;
                end
            end
            ST_MUL_LIN:  if (w_mdone) r_dvd <= DVD_W'(w_prod[76:9]);
            ST_DIV_LIN:  if (w_ddone) r_lin <= sat_rate(w_quo, r_sum[32], r_in.elapsed_us);
            ST_MUL_ANG1: if (w_mdone) r_t <= w_prod[52:0];
            ST_MUL_ANG2: if (w_mdone) r_dvd <= w_prod[100:28];
            ST_DIV_ANG:  if (w_ddone) r_ang <= sat_rate(w_quo, r_dd[32], r_in.elapsed_us);
            default: begin
                r_ci <= r_ci;
            end
        endcase
        if (r_state == ST_OUT && w_out_free) begin
            r_out.pos_x        <= r_acc_x;
            r_out.pos_y        <= r_acc_y;
            r_out.heading      <= r_acc_h;
            r_out.lin_velocity <= r_lin;
            r_out.ang_velocity <= r_ang;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // a new result word only comes from the output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("output word raised outside the output step");

    // the pose holds while the sequencer is idle
    a_pose_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> ($stable(r_acc_x) && $stable(r_acc_y) && $stable(r_acc_h)))
        else $error("pose changed while idle");

    // multiplier completions land only in multiply steps
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> (r_state == ST_MUL_DS || r_state == ST_MUL_P || r_state == ST_MUL_KQ ||
                     r_state == ST_MUL_U || r_state == ST_MUL_X || r_state == ST_MUL_Y ||
                     r_state == ST_MUL_LIN || r_state == ST_MUL_ANG1 ||
                     r_state == ST_MUL_ANG2))
        else $error("multiplier finished outside a multiply step");
`endif

endmodule

// ===== rtl/ddo_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ddo_mul
    import ddo_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mul_req     i_req,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [6:0]   r_n;
    logic [127:0] r_acc;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [64:0]  w_sum;

    // add the multiplicand into the top half when the low multiplier bit is set
    assign w_sum = {1'b0, r_acc[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == r_n - 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift the accumulator right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= 128'd0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_req.n;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[63:1]};
            r_b   <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc >> (7'd64 - r_n);

endmodule

// ===== rtl/ddo_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ddo_div
    import ddo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [19:0]      i_dvs,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [DVD_W-1:0] r_dq;
    logic [19:0]      r_rem;
    logic [19:0]      r_dvs;
    logic [20:0]      w_trial;
    logic             w_ge;
    logic [20:0]      w_diff;

    // trial subtract of the divisor from the shifted remainder
    assign w_trial = {r_rem, r_dq[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dvd;
            r_rem <= 20'd0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[19:0] : w_trial[19:0];
            r_dq  <= {r_dq[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dq;

endmodule

// ===== bench/odometry_checker.sv =====
// Checker for the wheel odometry block: predicts each pose word and compares it.
`timescale 1ns / 100ps

module odometry_checker
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);

    // Arctangent of 2^-i as binary angles
    localparam logic [31:0] ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    logic [23:0] meters_per_count;
    logic [23:0] inv_track;
    logic [31:0] last_left, last_right;
    logic [31:0] pose_x, pose_y, pose_heading;
    t_out_word   pose_queue[$];

    // Rotate the unit vector to a binary angle; fold the left half plane first
    function automatic void rotate_unit(input logic [31:0] ang,
                                        output logic signed [63:0] c,
                                        output logic signed [63:0] s);
        logic [31:0] a;
        logic flip;
        logic signed [63:0] x, y, z, t;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) begin
            a = a + 32'h8000_0000;
        end
        z = {{32{a[31]}}, a};
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z = z - $signed({32'd0, ATAN_TURN[i]});
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z = z + $signed({32'd0, ATAN_TURN[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Position step: doubled travel (Q24) times trig (Q30), rounded half up
    function automatic logic [31:0] pos_step(input logic signed [63:0] trav2,
                                             input logic signed [63:0] trig);
        logic [127:0] prod;
        logic [31:0] m;
        prod = {64'd0, magnitude(trav2)} * {64'd0, magnitude(trig)};
        prod = (prod + (128'd1 << (54 - POS_FRAC_BITS))) >> (55 - POS_FRAC_BITS);
        m = prod[31:0];
        return ((trav2 < 0) != (trig < 0)) ? 32'd0 - m : m;
    endfunction

    // Truncated, saturated rate: (a*b >> sh) / us
    function automatic logic [31:0] speed(input logic [63:0] a, input logic [63:0] b,
                                          input int sh, input logic neg,
                                          input logic [19:0] us);
        logic [127:0] v;
        logic [127:0] q;
        logic [31:0] cap, m;
        if (us == 20'd0) begin
            return 32'd0;
        end
        v = ({64'd0, a} * {64'd0, b}) >> sh;
        q = v / {108'd0, us};
        cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m = (q > {96'd0, cap}) ? cap : q[31:0];
        return neg ? 32'd0 - m : m;
    endfunction

    // Advance the pose by one tick and return the expected word
    task automatic integrate_tick(input t_in_word w, output t_out_word r);
        logic [31:0] dl32, dr32, dh, half;
        logic signed [63:0] dl, dr, ds2, dd, c, s, dpc;
        logic [63:0] p, kq, u, rnd;
        logic [127:0] wide;
        r.lin_velocity = '0;
        r.ang_velocity = '0;
        if (w.counts_valid) begin
            dl32 = w.left_count - last_left;
            dr32 = w.right_count - last_right;
            dl = {{32{dl32[31]}}, dl32};
            dr = {{32{dr32[31]}}, dr32};
            dpc = $signed({40'd0, meters_per_count});
            ds2 = dl * dpc + dr * dpc;
            dd = dr - dl;
            p = {40'd0, meters_per_count} * {40'd0, inv_track};
            wide = {64'd0, p} * 128'd683565276;
            kq = wide[83:20];
            u = $unsigned(dd) * kq;
            rnd = u + (64'd1 << 23);
            dh = rnd[55:24];
            rnd = u + (64'd1 << 24);
            half = rnd[56:25];
            last_left = w.left_count;
            last_right = w.right_count;
            rotate_unit(pose_heading + half, c, s);
            pose_x = pose_x + pos_step(ds2, c);
            pose_y = pose_y + pos_step(ds2, s);
            pose_heading = pose_heading + dh;
            r.lin_velocity = speed(magnitude(ds2), 64'd1000000, 9, ds2 < 0,
                                   w.elapsed_us);
            r.ang_velocity = speed(magnitude(dd) * 64'd1000000, p, 28, dd < 0,
                                   w.elapsed_us);
        end
        r.pos_x = pose_x;
        r.pos_y = pose_y;
        r.heading = pose_heading;
    endtask

    function automatic bit same_word(input t_out_word e, input t_out_word a);
        return e.pos_x == a.pos_x && e.pos_y == a.pos_y && e.heading == a.heading &&
               e.lin_velocity == a.lin_velocity && e.ang_velocity == a.ang_velocity;
    endfunction

    assign o_pending = pose_queue.size();

    // Track config, predict accepted ticks, compare returned words
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            meters_per_count <= 24'd41431;
            inv_track <= 24'd2688656;
            last_left <= '0;
            last_right <= '0;
            pose_x <= '0;
            pose_y <= '0;
            pose_heading <= '0;
            pose_queue.delete();
            o_fail_count <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DIST_PER_COUNT) begin
                    meters_per_count = i_cfg_data;
                end else begin
                    inv_track = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                integrate_tick(i_in_word, want);
                pose_queue.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (pose_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected pose word %h", i_out_word);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pose_queue.pop_front();
                    if (!same_word(want, i_out_word)) begin
                        if (o_fail_count < 10) begin
                            $display("pose mismatch at %0t", $time);
                            $display("  exp x %h y %h hdg %h lin %h ang %h", want.pos_x,
                                     want.pos_y, want.heading, want.lin_velocity,
                                     want.ang_velocity);
                            $display("  got x %h y %h hdg %h lin %h ang %h",
                                     i_out_word.pos_x, i_out_word.pos_y,
                                     i_out_word.heading, i_out_word.lin_velocity,
                                     i_out_word.ang_velocity);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_differential_drive_odometry.sv =====
// Testbench top for the wheel odometry block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    int fail_count, pending, results;
    int cycles = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;
    logic calm = 1'b0;
    logic [31:0] cur_left = '0, cur_right = '0;
    int n_ticks = 0, n_invalid = 0, n_still = 0;

    differential_drive_odometry dut (.*);

    odometry_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_word(i_in_word),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 18);
        end
    end

    // Offer one tick word and hold it until taken
    task automatic send_tick(input logic [31:0] l, input logic [31:0] r,
                             input logic v, input logic [19:0] us);
        t_in_word w;
        w.left_count = l;
        w.right_count = r;
        w.counts_valid = v;
        w.elapsed_us = us;
        if (!calm && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_ticks++;
        if (!v) begin
            n_invalid++;
        end else begin
            cur_left = l;
            cur_right = r;
        end
        if (us == 20'd0) begin
            n_still++;
        end
    endtask

    // Stop offering and wait until every pose word is back
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [23:0] dpc, input logic [23:0] iwb);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_DIST_PER_COUNT;
        i_cfg_data <= dpc;
        @(posedge i_clk);
        i_cfg_idx <= REG_INV_WHEEL_BASE;
        i_cfg_data <= iwb;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly plausible motion, some wild counts, read errors and odd times
    task automatic random_tick;
        logic [31:0] l, r;
        logic [19:0] us;
        logic v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            l = cur_left + 32'($urandom_range(4000)) - 32'd2000;
            r = cur_right + 32'($urandom_range(4000)) - 32'd2000;
        end else if (pick < 85) begin
            l = cur_left + 32'($urandom_range(200000)) - 32'd100000;
            r = cur_right + 32'($urandom_range(200000)) - 32'd100000;
        end else begin
            l = $urandom;
            r = $urandom;
        end
        v = ($urandom_range(99) >= 8);
        pick = $urandom_range(99);
        if (pick < 70) begin
            us = 20'($urandom_range(150000, 50000));
        end else if (pick < 80) begin
            us = '0;
        end else if (pick < 90) begin
            us = 20'($urandom_range(10, 1));
        end else begin
            us = 20'($urandom);
        end
        send_tick(l, r, v, us);
    endtask

    initial begin
        logic [23:0] dpc_set [6];
        logic [23:0] iwb_set [6];
        dpc_set = '{24'd41431, 24'hFFFFFF, 24'd0, 24'd1, 24'd0, 24'd41431};
        iwb_set = '{24'd2688656, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'd2688656};
        dpc_set[4] = 24'($urandom);
        iwb_set[4] = 24'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: still robot, straight, turns, counter wrap, read errors
        send_tick(32'd0, 32'd0, 1'b1, 20'd0);
        send_tick(32'd100, 32'd100, 1'b1, 20'd100000);
        send_tick(32'd300, 32'd100, 1'b1, 20'd100000);
        send_tick(32'd300, 32'd900, 1'b1, 20'd100000);
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 20'd1);
        send_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 20'hFFFFF);
        send_tick(32'd12345, 32'hFFFF_FFFB, 1'b0, 20'd1000);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 20'd50000);
        send_tick(32'd0, 32'd0, 1'b1, 20'd0);
        send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 20'd0);
        for (int k = 1; k <= 6; k++) begin
            send_tick(32'd0, 32'(k * 3000000), 1'b1, 20'd100000);
        end
        send_tick(32'hFFFF_FFFF, 32'h0, 1'b1, 20'hFFFFF);
        send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 20'd2);
        send_tick(32'h8000_0000, 32'h8000_0000, 1'b1, 20'd3);

        // Random phases across geometry settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                set_geometry(dpc_set[ph], iwb_set[ph]);
            end
            calm <= (ph == 3);
            for (int k = 0; k < 290; k++) begin
                if (ph == 1 && k == 40) begin
                    hold_go <= 1'b1;
                    random_tick();
                    hold_go <= 1'b0;
                end else begin
                    random_tick();
                end
                if (ph == 2 && k == 150) begin
                    drain();
                end
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        $display("Sent %0d ticks (%0d read errors, %0d zero-time), %0d pose words back,",
                 n_ticks, n_invalid, n_still, results);
        $display("over default, extreme, zero and random wheel geometry.");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_div.sv
rtl/differential_drive_odometry.sv
bench/odometry_checker.sv
bench/tb_differential_drive_odometry.sv
